@@ rtl/hfc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types, constants and the 16-bit fold used by the header checksum core.
// ----------------------------------------------------------------------------
package hfc_pkg;

   // Byte offset of the four-byte checksum field inside the header
   localparam int unsigned CSUM_FIELD_OFFSET = 36;
   localparam int unsigned CSUM_FIELD_LEN    = 4;
   localparam int unsigned CSUM_FIELD_END    = CSUM_FIELD_OFFSET + CSUM_FIELD_LEN;

   // Byte position counter, saturates at the end of the checksum field
   localparam int unsigned POS_W = 6;

   localparam logic [POS_W-1:0] FIELD_START_POS = POS_W'(CSUM_FIELD_OFFSET);
   localparam logic [POS_W-1:0] FIELD_END_POS   = POS_W'(CSUM_FIELD_END);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } hfc_req_type;

   typedef struct packed {
      logic [31:0] checksum;
      logic        short_header;
   } hfc_rsp_type;

   // Final sums of one header, waiting to be folded
   typedef struct packed {
      logic [31:0] byte_sum;
      logic [31:0] sum_of_sums;
      logic        short_header;
   } hfc_pend_type;

   // Fold a 32-bit sum to 16 bits with end-around carry
   function automatic logic [15:0] fold16(input logic [31:0] v);
      logic [16:0] b;
      b = {1'b0, v[15:0]} + {1'b0, v[31:16]};
      return b[15:0] + {15'd0, b[16]};
   endfunction

endpackage
`default_nettype wire

@@ rtl/hfc_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hfc_accum
// Running byte sum and sum of sums; hands the final sums of a header onward.
// ----------------------------------------------------------------------------
module hfc_accum (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire hfc_pkg::hfc_req_type  req_data,
   output logic                       pend_valid,
   input  wire logic                  pend_ready,
   output hfc_pkg::hfc_pend_type      pend_data
);
   import hfc_pkg::*;

   logic [31:0]      byte_sum_ff, byte_sum_in;
   logic [31:0]      sum_of_sums_ff, sum_of_sums_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             pend_valid_ff, pend_valid_in;
   hfc_pend_type     pend_ff, pend_in;

   logic             req_fire;
   logic             in_field;
   logic [7:0]       data_eff;
   logic [31:0]      byte_sum_add;
   logic [31:0]      sum_of_sums_add;
   logic [POS_W-1:0] pos_add;

   assign req_ready = !pend_valid_ff || pend_ready;
   assign req_fire  = req_valid && req_ready;

   // checksum field bytes count as zero
   assign in_field        = (pos_ff >= FIELD_START_POS) && (pos_ff < FIELD_END_POS);
   assign data_eff        = in_field ? 8'd0 : req_data.data_byte;
   assign byte_sum_add    = byte_sum_ff + {24'd0, data_eff};
   assign sum_of_sums_add = sum_of_sums_ff + byte_sum_add;
   assign pos_add         = (pos_ff < FIELD_END_POS) ? pos_ff + 1'b1 : pos_ff;

   always_comb begin
      byte_sum_in    = byte_sum_ff;
      sum_of_sums_in = sum_of_sums_ff;
      pos_in         = pos_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      if (pend_ready) begin
         pend_valid_in = 1'b0;
      end
      if (req_fire) begin
         if (req_data.last) begin
            byte_sum_in          = '0;
            sum_of_sums_in       = '0;
            pos_in               = '0;
            pend_valid_in        = 1'b1;
            pend_in.byte_sum     = byte_sum_add;
            pend_in.sum_of_sums  = sum_of_sums_add;
            pend_in.short_header = (pos_add < FIELD_END_POS);
         end else begin
            byte_sum_in    = byte_sum_add;
            sum_of_sums_in = sum_of_sums_add;
            pos_in         = pos_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_sum_ff    <= '0;
         sum_of_sums_ff <= '0;
         pos_ff         <= '0;
         pend_valid_ff  <= 1'b0;
      end else begin
         byte_sum_ff    <= byte_sum_in;
         sum_of_sums_ff <= sum_of_sums_in;
         pos_ff         <= pos_in;
         pend_valid_ff  <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

   assign pend_valid = pend_valid_ff;
   assign pend_data  = pend_ff;

`ifndef ASSERT_OFF
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.last |=> pos_ff == '0 && byte_sum_ff == '0 && sum_of_sums_ff == '0)
      else $error("sums not cleared after last word");

   a_pos_step : assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_data.last && pos_ff < FIELD_END_POS |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("byte position did not advance");

   a_field_zero : assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_data.last && in_field |=> byte_sum_ff == $past(byte_sum_ff))
      else $error("checksum field byte added to byte sum");
`endif

endmodule
`default_nettype wire

@@ rtl/hfc_fold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hfc_fold
// Folds the final sums to 16 bits each and holds the result word.
// ----------------------------------------------------------------------------
module hfc_fold (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pend_valid,
   output logic                       pend_ready,
   input  wire hfc_pkg::hfc_pend_type pend_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output hfc_pkg::hfc_rsp_type       rsp_data
);
   import hfc_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   hfc_rsp_type rsp_ff, rsp_in;
   logic        load;

   assign pend_ready = !rsp_valid_ff || rsp_ready;
   assign load       = pend_valid && pend_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.checksum     = {fold16(pend_data.sum_of_sums), fold16(pend_data.byte_sum)};
         rsp_in.short_header = pend_data.short_header;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_rise_needs_pend : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_valid))
      else $error("result appeared without pending sums");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !load)
      else $error("held result overwritten");

   a_fold_low : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_ff.checksum[15:0] == fold16($past(pend_data.byte_sum)))
      else $error("low half does not match folded byte sum");
`endif

endmodule
`default_nettype wire

@@ rtl/header_fletcher_checksum_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// header_fletcher_checksum_core
// Fletcher-32 style checksum over an image header, one byte per word.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+--------------------------------
//   req     | in        | req_valid/req_ready | data_byte, last
//   rsp     | out       | rsp_valid/rsp_ready | checksum, short_header
//
// Takes one req word every cycle while req_ready is high; the two chained
//   32-bit adders of the accumulator set that cycle.
// The rsp word passes through the pending register, then the output register.
// Reset (synchronous) clears both sums, the byte position and the valid bits.
// req_ready drops only while a finished result sits in both the pending
//   stage and the output register and rsp_ready is low.
// ----------------------------------------------------------------------------
module header_fletcher_checksum_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire hfc_pkg::hfc_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output hfc_pkg::hfc_rsp_type      rsp_data
);
   import hfc_pkg::*;

   // final sums of a header between accumulator and fold stage
   logic         pend_valid;
   logic         pend_ready;
   hfc_pend_type pend_data;

   // running sums, byte position, zeroing of the checksum field
   hfc_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .pend_valid (pend_valid),
      .pend_ready (pend_ready),
      .pend_data  (pend_data)
   );

   // end-around fold and output register
   hfc_fold u_fold (
      .clock      (clock),
      .reset      (reset),
      .pend_valid (pend_valid),
      .pend_ready (pend_ready),
      .pend_data  (pend_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

@@ sim/header_fletcher_checksum_core_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// header_fletcher_checksum_core_test
// Self-checking bench for the header checksum core. Headers of many lengths
// go in one byte per word with random gaps. A scoreboard predicts each
// folded checksum and short flag and checks every result word in order.
// ----------------------------------------------------------------------------
module header_fletcher_checksum_core_test;
   import hfc_pkg::*;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own running sums per header and a queue of the
   // result words still owed by the core.
   // -------------------------------------------------------------------------
   class checksum_scoreboard;
      bit [31:0]   run_byte_sum;
      bit [31:0]   run_sum_of_sums;
      bit [5:0]    next_pos;
      hfc_rsp_type owed_q[$];
      int unsigned error_count;

      function new();
         run_byte_sum    = '0;
         run_sum_of_sums = '0;
         next_pos        = '0;
         error_count     = 0;
      endfunction

      // 32 -> 16 with end-around carry
      function bit [15:0] fold_to_16(bit [31:0] v);
         bit [31:0] t;
         t = {16'd0, v[15:0]} + {16'd0, v[31:16]};
         t = {16'd0, t[15:0]} + {31'd0, t[16]};
         return t[15:0];
      endfunction

      function void note_word(hfc_req_type w);
         bit [7:0]    d;
         hfc_rsp_type owed;
         d = w.data_byte;
         // checksum field bytes add zero, sum of sums still steps
         if (next_pos >= FIELD_START_POS && next_pos < FIELD_END_POS)
            d = '0;
         run_byte_sum    += {24'd0, d};
         run_sum_of_sums += run_byte_sum;
         if (next_pos < FIELD_END_POS)
            next_pos++;
         if (w.last) begin
            owed.checksum     = {fold_to_16(run_sum_of_sums), fold_to_16(run_byte_sum)};
            owed.short_header = (next_pos < FIELD_END_POS);
            owed_q = {owed_q, owed};
            run_byte_sum    = '0;
            run_sum_of_sums = '0;
            next_pos        = '0;
         end
      endfunction

      function void check_word(hfc_rsp_type r);
         hfc_rsp_type owed;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result word, actual %h/%b",
                     $time, r.checksum, r.short_header);
            error_count++;
            return;
         end
         owed = owed_q.pop_front();
         if (r.checksum !== owed.checksum) begin
            $display("%0t: checksum mismatch, expected %h actual %h",
                     $time, owed.checksum, r.checksum);
            error_count++;
         end
         if (r.short_header !== owed.short_header) begin
            $display("%0t: short_header mismatch, expected %b actual %b",
                     $time, owed.short_header, r.short_header);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   hfc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   hfc_rsp_type rsp_data;

   checksum_scoreboard sb = new();

   // receiver hold-off request, raised by the stimulus for the pressure test
   bit          hold_off_request = 1'b0;
   int unsigned bytes_sent       = 0;

   header_fletcher_checksum_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #(12 * 1_000_000);
      $display("Simulation FAILED");
      $finish;
   end

   // Both channels are sampled at the edge, before the core's updates land.
   // Result checked before the new word is noted; results are registered
   // in the core, so a word taken now is never the one owed for this result.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_data);
         if (req_valid && req_ready)
            sb.note_word(req_data);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall before each result, with fast stretches. A long
   // hold-off is taken when the stimulus asks for it.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned stall;
      bit          fast;
      fast = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 5) == 0)
            fast = ~fast;
         stall = fast ? 0 : $urandom_range(0, 8);
         if (hold_off_request) begin
            stall            = 300;
            hold_off_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   task automatic send_word(input logic [7:0] d, input logic lst, input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.data_byte <= d;
      req_data.last      <= lst;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Byte values lean on the extremes; lo lifts the floor for the long header
   task automatic send_header(input int unsigned len, input bit no_gaps,
                              input int unsigned lo);
      logic [7:0] d;
      for (int unsigned i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0:       d = 8'h00;
            1:       d = 8'hff;
            default: d = 8'($urandom_range(lo, 255));
         endcase
         send_word(d, (i == len - 1), no_gaps ? 0 : $urandom_range(0, 8));
      end
   endtask

   // Idle the input until the core owes nothing; first wait on the clock so the
   // last accepted word has been noted
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one-byte headers at both byte extremes, back to back,
      // then a tiny short header with gaps
      send_word(8'hff, 1'b1, 0);
      send_word(8'h00, 1'b1, 0);
      send_word(8'hff, 1'b0, 0);
      send_word(8'h00, 1'b0, 3);
      send_word(8'hff, 1'b1, 0);
      drain_results();

      // lengths around the checksum field: ends before it, inside it,
      // exactly at its end, one past, and well past (saturated position)
      send_header(CSUM_FIELD_OFFSET,     1'b0, 0);
      send_header(CSUM_FIELD_OFFSET + 1, 1'b1, 0);
      send_header(CSUM_FIELD_END - 1,    1'b0, 0);
      send_header(CSUM_FIELD_END,        1'b0, 0);
      send_header(CSUM_FIELD_END + 1,    1'b1, 0);
      send_header(63,                    1'b0, 0);

      // pressure: receiver holds off while one-byte headers pour in, so
      // results back up and the core stalls its input
      hold_off_request = 1'b1;
      repeat (8) send_header(1, 1'b1, 0);
      drain_results();

      // random headers: short, near the field, and long
      while (bytes_sent < 1250) begin
         case ($urandom_range(0, 9))
            0, 1, 2:       len = $urandom_range(1, 12);
            3, 4, 5, 6:    len = $urandom_range(CSUM_FIELD_OFFSET - 2, CSUM_FIELD_END + 2);
            default:       len = $urandom_range(CSUM_FIELD_END + 3, 70);
         endcase
         send_header(len, ($urandom_range(0, 3) == 0), 0);
         if ($urandom_range(0, 15) == 0)
            drain_results();
      end

      // one long header of high bytes so the byte sum passes 16 bits and
      // both folds see a carry
      send_header(600, 1'b1, 240);

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ header_fletcher_checksum_core.f @@
rtl/hfc_pkg.sv
rtl/hfc_accum.sv
rtl/hfc_fold.sv
rtl/header_fletcher_checksum_core.sv
sim/header_fletcher_checksum_core_test.sv
